// File: hw/rtl/dcm_pkg.sv
// Shared types, constants and helper functions of the DNA context model counter.
package dcm_pkg;

  localparam int MAX_ORDER  = 8;
  localparam int COUNT_BITS = 16;
  localparam int CTX_W      = 2 * MAX_ORDER;
  localparam int CTX_DEPTH  = 1 << CTX_W;

  localparam int ORDER_W   = 4;
  localparam int ALPHA_W   = 16;
  localparam int MAXC_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int FREQ_W  = 32;
  localparam int TOTAL_W = 34;

  localparam int SYM_W        = 2;
  localparam int IN_TDATA_W   = ((SYM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((4 * FREQ_W + TOTAL_W + 7) / 8) * 8;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(8);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1);
  localparam logic [MAXC_W-1:0]  MAXC_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_MAXC  = 2'd2
  } cfg_idx_e;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef count_t [3:0] count_set_t;

  // Context mask for the given order, with the order clamped to 1..MAX_ORDER.
  function automatic logic [CTX_W-1:0] ctx_mask(input logic [ORDER_W-1:0] order);
    logic [ORDER_W-1:0] k;
    logic [CTX_W-1:0]   m;
    k = order;
    if (k == '0) begin
      k = ORDER_W'(1);
    end else if (k > ORDER_W'(MAX_ORDER)) begin
      k = ORDER_W'(MAX_ORDER);
    end
    m = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (ORDER_W'(i) < k) begin
        m[2*i +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/dcm_freq_pipe.sv
// Frequency pipeline: scales the four counts, sums them and holds the result item.
module dcm_freq_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dcm_pkg::count_set_t                 counts_i,
  input  logic [dcm_pkg::ALPHA_W-1:0]         alpha_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: freq_zero, freq_one, freq_two, freq_three, freq_total, zero fill.
  output logic [dcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dcm_pkg::*;

  logic                    va_q, vb_q;
  logic                    ready_a, ready_b;
  logic [FREQ_W-1:0]       prod_d [4];
  logic [FREQ_W-1:0]       prod_q [4];
  logic [FREQ_W-1:0]       freq_q [4];
  logic [TOTAL_W-1:0]      total_q;
  logic [TOTAL_W-1:0]      total_d;

  assign ready_b    = !vb_q || m_axis_tready;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = FREQ_W'(alpha_i) * FREQ_W'(counts_i[i]);
    end
  end

  // Each frequency carries a plus one, so the total carries four of them.
  assign total_d = TOTAL_W'(prod_q[0]) + TOTAL_W'(prod_q[1]) + TOTAL_W'(prod_q[2])
                 + TOTAL_W'(prod_q[3]) + TOTAL_W'(4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= in_valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready_a) begin
      prod_q <= prod_d;
    end
    if (va_q && ready_b) begin
      for (int i = 0; i < 4; i++) begin
        freq_q[i] <= prod_q[i] + FREQ_W'(1);
      end
      total_q <= total_d;
    end
  end

  assign m_axis_tvalid = vb_q;
  assign m_axis_tdata  = OUT_TDATA_W'({total_q, freq_q[3], freq_q[2], freq_q[1], freq_q[0]});

endmodule

// File: hw/rtl/dna_context_model_counter.sv
// Top level of the order-k DNA context model counter with its count memory.
//
// Items enter on the s_axis channel: tdata carries the 2-bit symbol, tuser the
// restart flag that clears the context before the symbol is used. For every
// accepted item one result item leaves on m_axis with the four frequencies
// 1 + alpha * count of the current context and their 34-bit sum.
// One item is accepted per clock cycle while the receiver keeps up. The result
// item reaches m_axis through a chain of registers: the count memory read is
// registered at the accepting edge, the bypass select and the scaling
// multipliers feed the product register, and the sum feeds the output register.
// The count memory is read and written once per cycle; a write to the context
// that the next item is reading is forwarded from a bypass register, so
// back-to-back symbols in one context see each other's updates.
// After reset a clearing pass zeroes all 65536 memory rows, one row per
// cycle; s_axis_tready stays low throughout the pass. Configuration
// registers may be written at any time during the pass and take effect on
// the next item. When the receiver stalls, results back up through the
// pipeline registers and s_axis_tready falls once every stage holds an item.
module dna_context_model_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dcm_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: symbol, zero fill.
  input  logic [dcm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Fields from bit 0 up: restart.
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: freq_zero, freq_one, freq_two, freq_three, freq_total, zero fill.
  output logic [dcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dcm_pkg::*;

  // Configuration registers.
  logic [ORDER_W-1:0] order_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [MAXC_W-1:0]  maxc_q;

  // Clearing pass.
  logic             clr_busy_q;
  logic [CTX_W-1:0] clr_addr_q;

  // Context tracking at the input.
  logic [CTX_W-1:0] mask;
  logic [CTX_W-1:0] ctx_q, ctx_d, ctx_cur;
  logic [SYM_W-1:0] sym_in;
  logic             in_fire;

  // Update stage, registered from the input.
  logic             v1_q;
  logic [CTX_W-1:0] ctx1_q;
  logic [SYM_W-1:0] sym1_q;
  logic             pipe_ready;
  logic             p_ready;
  logic             s1_fire;
  count_set_t       cnt_rd, cnt_inc, cnt_new;
  logic             halve;

  // Count memory with its registered read data and the write bypass.
  count_set_t       mem_q [CTX_DEPTH];
  count_set_t       mem_rd_q;
  logic             fwd_vld_q;
  logic [CTX_W-1:0] fwd_addr_q;
  count_set_t       fwd_data_q;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
      alpha_q <= ALPHA_RESET;
      maxc_q  <= MAXC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        CFG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_MAXC:  maxc_q  <= cfg_data_i[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  // The clearing pass walks every row once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CTX_W'(1);
      if (clr_addr_q == {CTX_W{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Input side. The context only depends on the symbols, so the next context
  // is known at acceptance and the memory read is issued in the same cycle.
  assign p_ready       = !v1_q || pipe_ready;
  assign s_axis_tready = p_ready && !clr_busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sym_in        = s_axis_tdata[SYM_W-1:0];
  assign mask          = ctx_mask(order_q);
  assign ctx_cur       = (s_axis_tuser[0] ? '0 : ctx_q) & mask;
  assign ctx_d         = {ctx_cur[CTX_W-SYM_W-1:0], sym_in} & mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        ctx_q <= ctx_d;
      end
      if (p_ready) begin
        v1_q <= in_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctx1_q <= ctx_cur;
      sym1_q <= sym_in;
    end
  end

  // Update stage. The bypass holds the most recent write, which is newer than
  // the memory read whenever the addresses match.
  assign cnt_rd  = (fwd_vld_q && (fwd_addr_q == ctx1_q)) ? fwd_data_q : mem_rd_q;
  assign s1_fire = v1_q && pipe_ready;

  always_comb begin
    cnt_inc         = cnt_rd;
    cnt_inc[sym1_q] = cnt_rd[sym1_q] + COUNT_BITS'(1);
    halve           = (maxc_q != '0) && (MAXC_W'(cnt_inc[sym1_q]) == maxc_q);
    cnt_new         = cnt_inc;
    if (halve) begin
      for (int i = 0; i < 4; i++) begin
        cnt_new[i] = cnt_inc[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (s1_fire) begin
      mem_q[ctx1_q] <= cnt_new;
    end
    if (in_fire) begin
      mem_rd_q <= mem_q[ctx_cur];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (s1_fire) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      fwd_addr_q <= ctx1_q;
      fwd_data_q <= cnt_new;
    end
  end

  // Frequencies come from the counts before the update.
  dcm_freq_pipe u_freq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v1_q),
    .in_ready_o    (pipe_ready),
    .counts_i      (cnt_rd),
    .alpha_i       (alpha_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // No item may enter while the clearing pass still owns the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !clr_busy_q)
    else $error("item accepted during the clearing pass");

  // The clearing pass and an item write never compete for the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_busy_q && v1_q))
    else $error("update stage busy during the clearing pass");

  // The clearing pass only ends after the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_addr_q) == {CTX_W{1'b1}}))
    else $error("clearing pass ended early");

  // With halving enabled, the counter of the written symbol may not be left at the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (maxc_q != '0)) |-> (MAXC_W'(cnt_new[sym1_q]) != maxc_q))
    else $error("counter written back at the halving limit");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the order-k DNA context model counter.
`timescale 1ns / 1ps

module testbench;
  import dcm_pkg::*;

  // The slowest parts of the run are the memory clearing pass after reset
  // and the random phases with heavy stalls. The limit leaves a wide margin
  // above the whole run.
  localparam int LIMIT_CYCLES = 1_000_000;
  // Pipeline allowance that settle() adds to its wait after the last result.
  localparam int LATENCY      = 2;
  localparam int BLOCKS       = 6;
  localparam int BLOCK_ITEMS  = 61;
  localparam int MAX_REPORTS  = 10;

  // One result item, laid out exactly as m_axis_tdata packs it.
  typedef struct packed {
    logic [TOTAL_W-1:0]     total;
    logic [3:0][FREQ_W-1:0] freq;
  } freq_set_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table: either a register write or an item.
  // Items with known_res set carry their result typed in.
  typedef struct {
    row_kind_e        kind;
    cfg_idx_e         reg_idx;
    logic [CFG_W-1:0] reg_val;
    logic [1:0]       sym;
    logic             restart;
    bit               known_res;
    freq_set_t        want;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_ORDER;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  int cycle_cnt = 0;
  int err_cnt   = 0;

  // Own copy of the block's state: the count table, the context history and
  // the three configuration registers.
  count_set_t           tally [CTX_DEPTH];
  logic [CTX_W-1:0]     ctx_hist;
  logic [ORDER_W-1:0]   ord_reg;
  logic [ALPHA_W-1:0]   alpha_reg;
  logic [MAXC_W-1:0]    maxc_reg;

  // Frequencies still owed by the block, oldest first.
  freq_set_t freq_due_q [$];
  stim_row_t dir_rows [$];

  string freq_names [4] = '{"freq_zero", "freq_one", "freq_two", "freq_three"};

  always #1 clk_i = ~clk_i;

  dna_context_model_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Computes the frequencies that one symbol sees and then updates the
  // counters and the context history the way the block does.
  function automatic freq_set_t estimate_freqs(input logic [1:0] sym, input logic restart);
    int unsigned        k;
    logic [CTX_W-1:0]   mask;
    logic [CTX_W-1:0]   ctx;
    logic [63:0]        f;
    logic [TOTAL_W-1:0] sum;
    count_t             bumped;
    freq_set_t          res;
    // An order of zero behaves as one, anything above the maximum as the maximum.
    if (ord_reg == '0) begin
      k = 1;
    end else if (ord_reg > ORDER_W'(MAX_ORDER)) begin
      k = MAX_ORDER;
    end else begin
      k = ord_reg;
    end
    mask = CTX_W'((32'd1 << (2 * k)) - 32'd1);
    if (restart) begin
      ctx_hist = '0;
    end
    // The stored history is cut down to the current order, so an order
    // change keeps whatever recent symbols still fit.
    ctx = ctx_hist & mask;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      f = 64'd1 + 64'(alpha_reg) * 64'(tally[ctx][i]);
      res.freq[i] = f[FREQ_W-1:0];
      sum += f[TOTAL_W-1:0];
    end
    res.total = sum;
    // The counter wraps at its width; halving looks at the wrapped value.
    bumped = count_t'(tally[ctx][sym] + 1'b1);
    tally[ctx][sym] = bumped;
    if (maxc_reg != '0 && bumped == maxc_reg) begin
      for (int i = 0; i < 4; i++) begin
        tally[ctx][i] = tally[ctx][i] >> 1;
      end
    end
    ctx_hist = ((ctx << 2) | CTX_W'(sym)) & mask;
    return res;
  endfunction

  function automatic void add_item(input logic [1:0] sym, input logic restart);
    stim_row_t row;
    row.kind      = ROW_ITEM;
    row.reg_idx   = CFG_ORDER;
    row.reg_val   = '0;
    row.sym       = sym;
    row.restart   = restart;
    row.known_res = 1'b0;
    row.want      = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic [1:0] sym, input logic restart,
                                    input logic [FREQ_W-1:0] f0, input logic [FREQ_W-1:0] f1,
                                    input logic [FREQ_W-1:0] f2, input logic [FREQ_W-1:0] f3,
                                    input logic [TOTAL_W-1:0] tot);
    stim_row_t row;
    row.kind       = ROW_ITEM;
    row.reg_idx    = CFG_ORDER;
    row.reg_val    = '0;
    row.sym        = sym;
    row.restart    = restart;
    row.known_res  = 1'b1;
    row.want.freq  = {f3, f2, f1, f0};
    row.want.total = tot;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_write(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    stim_row_t row;
    row.kind      = ROW_CFG;
    row.reg_idx   = idx;
    row.reg_val   = val;
    row.sym       = '0;
    row.restart   = 1'b0;
    row.known_res = 1'b0;
    row.want      = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("error at cycle %0d: %s", cycle_cnt, msg);
    end
  endfunction

  // Offers one item, with random hold-off first, and records what the block
  // owes for it once it is accepted. Called and left at a falling edge.
  task automatic push_item(input logic [1:0] sym, input logic restart,
                           input bit known_res, input freq_set_t want);
    freq_set_t guess;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(sym);
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    // The predictor runs even for rows with a typed result, so that its
    // state follows the block.
    guess = estimate_freqs(sym, restart);
    freq_due_q.push_back(known_res ? want : guess);
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until the block has handed back every
  // result it owes, plus the pipeline depth for good measure.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (freq_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  // Writes one register and updates the predictor's copy. The enable is
  // held for one cycle and is low again when the task returns, so that
  // back-to-back writes never drive it twice in one step.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORDER: begin
        ord_reg = val[ORDER_W-1:0];
      end
      CFG_ALPHA: begin
        alpha_reg = val[ALPHA_W-1:0];
      end
      CFG_MAXC: begin
        maxc_reg = val[MAXC_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // The receiver decides at every falling edge whether it takes a result
  // at the next rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every accepted result is compared field by field with the oldest
  // expectation.
  always @(posedge clk_i) begin : check_results
    freq_set_t got;
    freq_set_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(freq_set_t)-1:0];
      if (freq_due_q.size() == 0) begin
        flag_error("result item arrived with nothing expected");
      end else begin
        want = freq_due_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got.freq[i] !== want.freq[i]) begin
            flag_error($sformatf("%s expected %0d, got %0d",
                                 freq_names[i], want.freq[i], got.freq[i]));
          end
        end
        if (got.total !== want.total) begin
          flag_error($sformatf("freq_total expected %0d, got %0d", want.total, got.total));
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : main
    logic [1:0]         motif [4];
    logic [1:0]         sym;
    logic [ORDER_W-1:0] ord;
    logic [CFG_W-1:0]   val;

    for (int c = 0; c < CTX_DEPTH; c++) begin
      tally[c] = '0;
    end
    ctx_hist  = '0;
    ord_reg   = ORDER_RESET;
    alpha_reg = ALPHA_RESET;
    maxc_reg  = MAXC_RESET;

    // Directed table. The first rows run with the reset settings (order 8,
    // alpha 1, no halving) on a freshly cleared table, so their results can
    // be read off directly. Then come an order of zero, which acts as one,
    // the largest alpha, an order written with all bits set and one just
    // above the maximum (both act as the maximum, and the history left from
    // order one survives the change), halving at a count of one, alpha zero
    // with the largest halving threshold, and finally a small threshold.
    add_known(2'd0, 1'b0, 1, 1, 1, 1, 4);
    add_known(2'd0, 1'b1, 2, 1, 1, 1, 5);
    add_known(2'd3, 1'b1, 3, 1, 1, 1, 6);
    add_known(2'd1, 1'b0, 1, 1, 1, 1, 4);
    add_known(2'd2, 1'b0, 1, 1, 1, 1, 4);
    add_write(CFG_ORDER, 16'd0);
    add_write(CFG_ALPHA, 16'hFFFF);
    add_known(2'd3, 1'b1, 131071, 1, 1, 65536, 196609);
    add_known(2'd1, 1'b0, 1, 65536, 1, 1, 65539);
    add_write(CFG_ORDER, 16'hFFFF);
    add_known(2'd2, 1'b0, 1, 1, 1, 1, 4);
    add_known(2'd2, 1'b0, 1, 1, 1, 1, 4);
    add_write(CFG_ORDER, 16'd9);
    add_item(2'd1, 1'b0);
    add_write(CFG_MAXC, 16'd1);
    add_item(2'd0, 1'b1);
    add_item(2'd1, 1'b0);
    add_item(2'd1, 1'b0);
    add_write(CFG_MAXC, 16'hFFFF);
    add_write(CFG_ALPHA, 16'd0);
    add_known(2'd3, 1'b1, 1, 1, 1, 1, 4);
    add_known(2'd2, 1'b0, 1, 1, 1, 1, 4);
    add_write(CFG_ORDER, 16'd1);
    add_write(CFG_ALPHA, 16'd1);
    add_write(CFG_MAXC, 16'd2);
    add_item(2'd1, 1'b1);
    add_item(2'd1, 1'b0);
    add_item(2'd1, 1'b0);
    add_item(2'd2, 1'b0);
    add_item(2'd0, 1'b1);
    add_item(2'd3, 1'b0);

    // Reset once. The block then clears its memory, which holds off the
    // first item for a while; the sender simply waits on tready.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[n].reg_idx, dir_rows[n].reg_val);
      end else begin
        push_item(dir_rows[n].sym, dir_rows[n].restart, dir_rows[n].known_res,
                  dir_rows[n].want);
      end
    end

    // Random part in three phases: receiver stalls often, then the sender idles,
    // then neither. Each block starts from a drained pipeline with fresh
    // settings. Half the symbols follow a short repeating motif so that a
    // few contexts fill up and reach the halving threshold.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 29;
          snk_idle_pct = 60;
        end
        1: begin
          src_idle_pct = 60;
          snk_idle_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        settle();
        case ($urandom_range(9))
          0: ord = 4'd0;
          1: ord = 4'd15;
          2, 3, 4, 5: ord = ORDER_W'($urandom_range(1, 3));
          default: ord = ORDER_W'($urandom_range(1, 15));
        endcase
        // The bits above the order field are don't-care and get random values.
        write_reg(CFG_ORDER, {12'($urandom), ord});
        case ($urandom_range(5))
          0: val = 16'd0;
          1: val = 16'd1;
          2: val = 16'hFFFF;
          default: val = CFG_W'($urandom_range(65535));
        endcase
        write_reg(CFG_ALPHA, val);
        case ($urandom_range(5))
          0: val = 16'd0;
          1: val = 16'hFFFF;
          2, 3: val = CFG_W'($urandom_range(2, 12));
          4: val = 16'd1;
          default: val = CFG_W'($urandom_range(65535));
        endcase
        write_reg(CFG_MAXC, val);
        for (int i = 0; i < 4; i++) begin
          motif[i] = 2'($urandom_range(3));
        end
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          sym = ($urandom_range(99) < 50) ? motif[n % 4] : 2'($urandom_range(3));
          push_item(sym, $urandom_range(99) < 4, 1'b0, '0);
        end
      end
    end

    settle();
    if (err_cnt == 0 && freq_due_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
